/* src/alcs_pkg.sv */
`default_nettype none

package alcs_pkg;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned LEN_EN_BIT = 6;
  localparam int unsigned TRIG_BIT = 7;
  localparam int unsigned SEQ_W = 3;
  localparam logic [1:0] WAVE_CHANNEL = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_LENGTH    = 2'd1,
    ACT_TRIGGER   = 2'd2,
    ACT_SEQ_RESET = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [1:0] channel;
    logic [7:0] value;
    logic       dac_on;
  } req_t;

  // broadcast from the top level to every channel lane
  typedef struct packed {
    logic       fire;
    logic       clock_len;
    logic       len_write;
    logic       trigger;
    logic       step_even;
    logic [7:0] value;
    logic       dac_on;
  } chan_ctrl_t;

endpackage

`default_nettype wire

/* src/alcs_in_reg.sv */
`default_nettype none

module alcs_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire alcs_pkg::req_t req_i,
  input  wire logic          advance_i,
  output logic               stall_o,
  output logic               valid_o,
  output alcs_pkg::req_t     req_o
);

  logic           valid_q, valid_d;
  alcs_pkg::req_t req_q;
  logic           load;

  // the stage takes a new request when empty or when its request moves on
  assign stall_o = valid_q && !advance_i;
  assign load    = in_valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

/* src/alcs_chan.sv */
`default_nettype none

module alcs_chan #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire alcs_pkg::chan_ctrl_t          ctrl_i,
  input  wire logic                          sel_i,
  output logic [alcs_pkg::CNT_W-1:0]         cnt_d_o,
  output logic                               on_d_o
);

  localparam logic [alcs_pkg::CNT_W-1:0] MaxLen  = alcs_pkg::CNT_W'(MAX_LENGTH);
  localparam logic [alcs_pkg::CNT_W-1:0] MaxLess = alcs_pkg::CNT_W'(MAX_LENGTH - 1);
  localparam logic [7:0]                 LenMask = 8'(MAX_LENGTH - 1);
  localparam logic [alcs_pkg::CNT_W-1:0] CntOne  = alcs_pkg::CNT_W'(1);

  logic [alcs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       en_q, en_d;
  logic                       on_q, on_d;

  logic [alcs_pkg::CNT_W-1:0] trig_cnt;
  logic [alcs_pkg::CNT_W-1:0] trig_dec;
  logic                       trig_prev_en;
  logic                       new_en;
  logic                       extra_clk;

  assign new_en = ctrl_i.value[alcs_pkg::LEN_EN_BIT];

  // trigger: a zero counter reloads to max and counts as length disabled
  always_comb begin
    trig_cnt     = cnt_q;
    trig_prev_en = en_q;
    if (cnt_q == '0) begin
      trig_cnt     = MaxLen;
      trig_prev_en = 1'b0;
    end
  end

  assign extra_clk = !trig_prev_en && new_en && ctrl_i.step_even && (trig_cnt != '0);
  assign trig_dec  = trig_cnt - CntOne;

  always_comb begin
    cnt_d = cnt_q;
    en_d  = en_q;
    on_d  = on_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.clock_len) begin
        if (en_q && (cnt_q != '0)) begin
          cnt_d = cnt_q - CntOne;
          if (cnt_d == '0) begin
            on_d = 1'b0;
          end
        end
      end else if (sel_i && ctrl_i.len_write) begin
        cnt_d = MaxLen - {1'b0, ctrl_i.value & LenMask};
      end else if (sel_i && ctrl_i.trigger) begin
        on_d  = 1'b1;
        cnt_d = trig_cnt;
        if (extra_clk) begin
          cnt_d = trig_dec;
          if (trig_dec == '0) begin
            if (ctrl_i.value[alcs_pkg::TRIG_BIT]) begin
              cnt_d = MaxLess;
            end else begin
              on_d = 1'b0;
            end
          end
        end
        if (!ctrl_i.dac_on) begin
          on_d = 1'b0;
        end
        en_d = new_en;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      en_q  <= 1'b0;
      on_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      en_q  <= en_d;
      on_q  <= on_d;
    end
  end

  assign cnt_d_o = cnt_d;
  assign on_d_o  = on_d;

endmodule

`default_nettype wire

/* src/apu_length_counter_sequencer.sv */
// Length counters and frame sequencer of a four-channel sound unit.
// Input channel: in_valid_i / in_stall_o carry one request per cycle, made of
// action_i (tick, length write, trigger write, sequencer reset), channel_i,
// value_i and dac_on_i. A request is taken at a clock edge with in_valid_i high
// and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result per request:
// channel_status_o (on flags), step_now_o (sequencer step) and count_now_o
// (addressed channel's length counter), all as they stand after the request.
// A taken request passes from the request register through the channel lanes
// into the result register, where out_valid_o rises; a stalled result can hold
// it in the request register.
// Throughput is one request per cycle while no result is stalled; the state
// update of each request is finished in the cycle it leaves the request
// register, so the next request follows directly.
// While out_stall_i holds a result, a request already in the request register
// waits there and in_stall_o is high in that same cycle; an empty request
// register still takes one request first. in_stall_o falls once the result
// is taken.
// Reset clears the length counters, channel flags, the step and both valid flags.
`default_nettype none

module apu_length_counter_sequencer #(
  parameter int unsigned PULSE_MAX_LENGTH = 64,
  parameter int unsigned WAVE_MAX_LENGTH  = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [1:0]                    channel_i,
  input  wire logic [7:0]                    value_i,
  input  wire logic                          dac_on_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [alcs_pkg::NUM_CH-1:0]        channel_status_o,
  output logic [alcs_pkg::SEQ_W-1:0]         step_now_o,
  output logic [alcs_pkg::CNT_W-1:0]         count_now_o
);

  alcs_pkg::req_t       in_req;
  alcs_pkg::req_t       st_req;
  logic                 st_valid;
  logic                 advance;
  logic                 fire;
  alcs_pkg::chan_ctrl_t ctrl;

  logic [alcs_pkg::SEQ_W-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic [alcs_pkg::NUM_CH-1:0] status_q;
  logic [alcs_pkg::SEQ_W-1:0]  step_now_q;
  logic [alcs_pkg::CNT_W-1:0]  count_q;

  logic [alcs_pkg::CNT_W-1:0] cnt_next [alcs_pkg::NUM_CH];
  logic [alcs_pkg::NUM_CH-1:0] on_next;

  assign in_req.action  = alcs_pkg::action_e'(action_i);
  assign in_req.channel = channel_i;
  assign in_req.value   = value_i;
  assign in_req.dac_on  = dac_on_i;

  // result register is free or being emptied this cycle
  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = st_valid && advance;

  alcs_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_i     (in_req),
    .advance_i (advance),
    .stall_o   (in_stall_o),
    .valid_o   (st_valid),
    .req_o     (st_req)
  );

  always_comb begin
    step_d = step_q;
    case (st_req.action)
      alcs_pkg::ACT_TICK:      step_d = step_q + alcs_pkg::SEQ_W'(1);
      alcs_pkg::ACT_SEQ_RESET: step_d = '0;
      default:                 step_d = step_q;
    endcase
  end

  // counters are clocked on even steps after the advance
  assign ctrl.fire      = fire;
  assign ctrl.clock_len = (st_req.action == alcs_pkg::ACT_TICK) && !step_d[0];
  assign ctrl.len_write = (st_req.action == alcs_pkg::ACT_LENGTH);
  assign ctrl.trigger   = (st_req.action == alcs_pkg::ACT_TRIGGER);
  assign ctrl.step_even = !step_q[0];
  assign ctrl.value     = st_req.value;
  assign ctrl.dac_on    = st_req.dac_on;

  for (genvar g = 0; g < alcs_pkg::NUM_CH; g++) begin : g_chan
    alcs_chan #(
      .MAX_LENGTH((2'(g) == alcs_pkg::WAVE_CHANNEL) ? WAVE_MAX_LENGTH : PULSE_MAX_LENGTH)
    ) u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (st_req.channel == 2'(g)),
      .cnt_d_o(cnt_next[g]),
      .on_d_o (on_next[g])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q   <= on_next;
      step_now_q <= step_d;
      count_q    <= cnt_next[st_req.channel];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_status_o = status_q;
  assign step_now_o       = step_now_q;
  assign count_now_o      = count_q;

endmodule

`default_nettype wire

/* src/alcs_checker.sv */
`default_nettype none

module alcs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] channel_status_o,
  input wire logic [2:0] step_now_o,
  input wire logic [8:0] count_now_o
);

  // input side only backs up behind a full, stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register can drain");

  // a new result needs a request taken earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching request");

  // a stalled result keeps its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(channel_status_o) && $stable(step_now_o)
       && $stable(count_now_o)))
    else $error("stalled result changed");

  // a length counter never exceeds the largest maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_now_o <= 9'd256))
    else $error("length count out of range");

endmodule

bind apu_length_counter_sequencer alcs_checker u_alcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .channel_status_o(channel_status_o),
  .step_now_o      (step_now_o),
  .count_now_o     (count_now_o)
);

`default_nettype wire

/* test/apu_length_checker.sv */
module apu_length_checker
  import alcs_pkg::*;
#(
  parameter int unsigned PULSE_MAX_LENGTH = 64,
  parameter int unsigned WAVE_MAX_LENGTH  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          action_i,
  input  logic [1:0]          channel_i,
  input  logic [7:0]          value_i,
  input  logic                dac_on_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [NUM_CH-1:0]   channel_status_i,
  input  logic [SEQ_W-1:0]    step_now_i,
  input  logic [CNT_W-1:0]    count_now_i,
  output int                  pending_o,
  output int                  mismatch_o,
  output int                  checked_o
);

  typedef struct packed {
    logic [NUM_CH-1:0] status;
    logic [SEQ_W-1:0]  seq_pos;
    logic [CNT_W-1:0]  count;
  } snapshot_t;

  // predicted state of the four channels and the frame sequencer
  logic [CNT_W-1:0] len_cnt [NUM_CH];
  logic             len_en  [NUM_CH];
  logic             ch_on   [NUM_CH];
  logic [SEQ_W-1:0] seq_pos;

  snapshot_t snapshot_q[$];
  int        mismatches;
  int        checked;

  function automatic logic [CNT_W-1:0] max_len(input logic [1:0] ch);
    return (ch == WAVE_CHANNEL) ? CNT_W'(WAVE_MAX_LENGTH) : CNT_W'(PULSE_MAX_LENGTH);
  endfunction

  task automatic clear_state();
    int i;
    for (i = 0; i < NUM_CH; i++) begin
      len_cnt[i] = '0;
      len_en[i]  = 1'b0;
      ch_on[i]   = 1'b0;
    end
    seq_pos = '0;
  endtask

  task automatic advance_state(input action_e act, input logic [1:0] ch,
                               input logic [7:0] v, input logic dac);
    logic [CNT_W-1:0] mx;
    logic             prev_en;
    logic             new_en;
    int               i;
    mx = max_len(ch);
    case (act)
      ACT_TICK: begin
        seq_pos = seq_pos + SEQ_W'(1);
        if (!seq_pos[0]) begin
          for (i = 0; i < NUM_CH; i++) begin
            if (len_en[i] && len_cnt[i] != '0) begin
              len_cnt[i] = len_cnt[i] - CNT_W'(1);
              if (len_cnt[i] == '0) ch_on[i] = 1'b0;
            end
          end
        end
      end
      ACT_LENGTH: begin
        len_cnt[ch] = mx - ({1'b0, v} & (mx - CNT_W'(1)));
      end
      ACT_TRIGGER: begin
        prev_en = len_en[ch];
        new_en  = v[LEN_EN_BIT];
        ch_on[ch] = 1'b1;
        // empty counter reloads and behaves as if length was disabled before
        if (len_cnt[ch] == '0) begin
          len_cnt[ch] = mx;
          prev_en = 1'b0;
        end
        // extra clock when enabling length on a step that clocks
        if (!prev_en && new_en && !seq_pos[0] && len_cnt[ch] != '0) begin
          len_cnt[ch] = len_cnt[ch] - CNT_W'(1);
          if (len_cnt[ch] == '0) begin
            if (v[TRIG_BIT]) len_cnt[ch] = mx - CNT_W'(1);
            else ch_on[ch] = 1'b0;
          end
        end
        if (!dac) ch_on[ch] = 1'b0;
        len_en[ch] = new_en;
      end
      default: begin
        seq_pos = '0;
      end
    endcase
  endtask

  function automatic snapshot_t current_snapshot(input logic [1:0] ch);
    snapshot_t s;
    int        i;
    for (i = 0; i < NUM_CH; i++) s.status[i] = ch_on[i];
    s.seq_pos = seq_pos;
    s.count   = len_cnt[ch];
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    snapshot_t want;
    snapshot_t seen;
    if (!rst_ni) begin
      clear_state();
      snapshot_q.delete();
      mismatches = 0;
      checked    = 0;
      pending_o  <= 0;
      mismatch_o <= 0;
      checked_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = {channel_status_i, step_now_i, count_now_i};
        if (snapshot_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %h step %0d count %0d",
                     seen.status, seen.seq_pos, seen.count);
          mismatches++;
        end else begin
          want = snapshot_q.pop_front();
          checked++;
          if (seen !== want) begin
            if (mismatches < 10)
              $display("mismatch: expected status %h step %0d count %0d,",
                       want.status, want.seq_pos, want.count,
                       " got status %h step %0d count %0d",
                       seen.status, seen.seq_pos, seen.count);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_state(action_e'(action_i), channel_i, value_i, dac_on_i);
        snapshot_q.push_back(current_snapshot(channel_i));
      end
      pending_o  <= snapshot_q.size();
      mismatch_o <= mismatches;
      checked_o  <= checked;
    end
  end

endmodule

/* test/apu_length_counter_sequencer_tb.sv */
module apu_length_counter_sequencer_tb;
  import alcs_pkg::*;

  localparam int unsigned PULSE_LEN = 64;
  localparam int unsigned WAVE_LEN  = 256;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 40;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        action;
  logic [1:0]        channel;
  logic [7:0]        value;
  logic              dac_on;
  logic              out_valid;
  logic              out_stall;
  logic [NUM_CH-1:0] channel_status;
  logic [SEQ_W-1:0]  step_now;
  logic [CNT_W-1:0]  count_now;

  int pending;
  int mismatches;
  int checked;
  int sent;
  int snd_pct;
  int rcv_pct;
  int quiet = 0;
  int hold_req;

  apu_length_counter_sequencer #(
    .PULSE_MAX_LENGTH(PULSE_LEN),
    .WAVE_MAX_LENGTH (WAVE_LEN)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .channel_i       (channel),
    .value_i         (value),
    .dac_on_i        (dac_on),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .channel_status_o(channel_status),
    .step_now_o      (step_now),
    .count_now_o     (count_now)
  );

  apu_length_checker #(
    .PULSE_MAX_LENGTH(PULSE_LEN),
    .WAVE_MAX_LENGTH (WAVE_LEN)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .channel_i       (channel),
    .value_i         (value),
    .dac_on_i        (dac_on),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .channel_status_i(channel_status),
    .step_now_i      (step_now),
    .count_now_i     (count_now),
    .pending_o       (pending),
    .mismatch_o      (mismatches),
    .checked_o       (checked)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result side: random stalls, or a long hold when asked for
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("apu_length_counter_sequencer_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(input action_e act, input logic [1:0] ch, input logic [7:0] v,
                      input logic dac);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    value    <= v;
    dac_on   <= dac;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random();
    int unsigned r;
    action_e     act;
    logic [1:0]  ch;
    logic [7:0]  v;
    logic        dac;
    r   = $urandom_range(99);
    ch  = 2'($urandom_range(3));
    v   = 8'($urandom_range(255));
    dac = ($urandom_range(99) < 85);
    if (r < 40) begin
      act = ACT_TICK;
    end else if (r < 60) begin
      act = ACT_LENGTH;
      // mostly short lengths so counters actually run out
      if ($urandom_range(2) != 0) begin
        v[5:0] = 6'h3f - 6'($urandom_range(3));
        if (ch == WAVE_CHANNEL) v[7:6] = 2'b11;
      end
    end else if (r < 93) begin
      act = ACT_TRIGGER;
    end else begin
      act = ACT_SEQ_RESET;
    end
    send(act, ch, v, dac);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int n);
    snd_pct = s_pct;
    rcv_pct = r_pct;
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    action   = ACT_TICK;
    channel  = '0;
    value    = '0;
    dac_on   = 1'b0;
    hold_req = 0;
    snd_pct  = 0;
    rcv_pct  = 0;
    sent     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases
    send(ACT_TICK,      2'd3, 8'hff, 1'b1);
    send(ACT_SEQ_RESET, 2'd1, 8'h00, 1'b0);
    send(ACT_LENGTH,    2'd0, 8'h00, 1'b1);
    send(ACT_LENGTH,    2'd1, 8'hff, 1'b0);
    send(ACT_LENGTH,    2'd2, 8'h00, 1'b1);
    send(ACT_LENGTH,    2'd3, 8'hff, 1'b1);
    send(ACT_TRIGGER,   2'd0, 8'hc0, 1'b1);
    // extra clock empties the counter without bit 7: channel goes off
    send(ACT_TRIGGER,   2'd1, 8'h40, 1'b1);
    // extra clock empties the counter with bit 7: reloads max minus one
    send(ACT_TRIGGER,   2'd3, 8'hc0, 1'b1);
    send(ACT_TRIGGER,   2'd2, 8'h80, 1'b0);
    send(ACT_TRIGGER,   2'd2, 8'hff, 1'b1);
    send(ACT_TICK,      2'd0, 8'h55, 1'b0);
    send(ACT_TICK,      2'd1, 8'haa, 1'b1);
    send(ACT_TICK,      2'd1, 8'h00, 1'b1);
    // counter already zero must not wrap
    send(ACT_TICK,      2'd1, 8'hff, 1'b0);
    send(ACT_TRIGGER,   2'd1, 8'h00, 1'b1);
    send(ACT_LENGTH,    2'd1, 8'h3f, 1'b1);
    send(ACT_TICK,      2'd2, 8'h00, 1'b1);
    // odd step: no extra clock
    send(ACT_TRIGGER,   2'd1, 8'h40, 1'b1);
    send(ACT_TICK,      2'd1, 8'h00, 1'b1);
    send(ACT_SEQ_RESET, 2'd2, 8'haa, 1'b0);
    send(ACT_TRIGGER,   2'd0, 8'h3f, 1'b0);
    send(ACT_LENGTH,    2'd2, 8'h80, 1'b1);
    drain();

    // back-pressure: hold results while requests keep coming
    snd_pct = 0;
    rcv_pct = 0;
    hold_req++;
    repeat (30) send_random();
    drain();

    run_phase(0,  0,  270);
    run_phase(81, 0,  270);
    run_phase(0,  81, 270);
    run_phase(22, 22, 270);

    repeat (6) @(posedge clk_i);
    $display("%0d requests sent: corner cases, a long result hold and four idle/stall mixes",
             sent);
    $display("%0d results compared, %0d mismatches, %0d still pending",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("apu_length_counter_sequencer_tb OK");
    end else begin
      $display("apu_length_counter_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule
